[rtl/core/p31wc_pkg.sv]
package p31wc_pkg;

  // Field widths of the channels
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned GEN_W      = 31;
  localparam int unsigned SKIP_W     = 16;
  localparam int unsigned TOTAL_W    = 25;
  localparam int unsigned ALIGN_W    = 2;
  localparam int unsigned ERR_W      = 32;
  localparam int unsigned POS_W      = 24;
  localparam int unsigned COUNTED_W  = 25;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // Generator taps for x^31 + x^28 + 1
  localparam int unsigned TAP_A = 30;
  localparam int unsigned TAP_B = 27;

  // Reset values
  localparam logic [GEN_W-1:0]   GEN_RESET   = 31'h7FFF_FFFF;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 25'h100_0000;
  localparam logic [POS_W-1:0]   POS_MAX     = 24'hFF_FFFF;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALIGN = 8'd0,
    REG_SKIP  = 8'd1,
    REG_TOTAL = 8'd2,
    REG_SEED  = 8'd3
  } cfg_reg_e;

  // Alignment modes; the unused code behaves as direct
  typedef enum logic [ALIGN_W-1:0] {
    ALIGN_DIRECT = 2'd0,
    ALIGN_LEFT   = 2'd1,
    ALIGN_RIGHT  = 2'd2
  } align_e;

  // Control from the checker to the pattern generator
  typedef struct packed {
    logic load;
    logic advance;
  } gen_ctrl_t;

endpackage

[rtl/core/p31wc_if.sv]
// Received word channel
interface p31wc_word_if;
  import p31wc_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] received_word;

  modport source (output valid, output received_word, input ready);
  modport sink (input valid, input received_word, output ready);
endinterface

// Check result channel
interface p31wc_result_if;
  import p31wc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 compared;
  logic                 mismatch;
  logic [WORD_W-1:0]    aligned_word;
  logic [WORD_W-1:0]    expected_word;
  logic [ERR_W-1:0]     error_total;
  logic                 first_error_seen;
  logic [POS_W-1:0]     first_error_position;
  logic [COUNTED_W-1:0] words_counted;
  logic                 run_done;

  modport source (
    output valid, output compared, output mismatch, output aligned_word,
    output expected_word, output error_total, output first_error_seen,
    output first_error_position, output words_counted, output run_done,
    input ready
  );
  modport sink (
    input valid, input compared, input mismatch, input aligned_word,
    input expected_word, input error_total, input first_error_seen,
    input first_error_position, input words_counted, input run_done,
    output ready
  );
endinterface

// Configuration write channel
interface p31wc_cfg_if;
  import p31wc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/prbs31_word_checker.sv]
// Channel   Dir  Payload                                         Transfer
// word_i    in   received_word[31:0]                             valid & ready
// result_o  out  compared, mismatch, aligned/expected words,     valid & ready
//                error_total, first error, words_counted, run_done
// cfg_i     in   index[7:0], data[31:0]                          valid & ready
//
// One word is checked per cycle while the result channel is not stalled. A word
// passes through an input register, and the whole check (32-bit pattern step,
// alignment, window and counters) is combinational into the result register.
// The counter and pattern state update in the cycle the word moves into the
// result register. A stalled result holds the input register; the input
// side keeps taking words while the input register can drain.
// Reset is asynchronous and active low and restores all but the data registers.
module prbs31_word_checker
  import p31wc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  p31wc_word_if.sink    word_i,
  p31wc_result_if.source result_o,
  p31wc_cfg_if.sink     cfg_i
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > 26) ? COUNT_WIDTH : 26;

  // Configuration registers
  logic [ALIGN_W-1:0] align_q;
  logic [SKIP_W-1:0]  skip_q;
  logic [TOTAL_W-1:0] total_q;
  logic               cfg_xfer;
  gen_ctrl_t          gen_ctrl;

  // Input register
  logic              in_valid_q;
  logic [WORD_W-1:0] in_word_q;
  logic              proc;

  // Check state
  logic [WORD_W-1:0]      prev_word_q;
  logic                   prev_valid_q;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [ERR_W-1:0]       err_q, err_d;
  logic                   first_q;
  logic [POS_W-1:0]       first_idx_q;

  // Check datapath
  align_e            mode;
  logic [WORD_W-1:0] gen_word;
  logic [WORD_W-1:0] aligned;
  logic [CMP_W-1:0]  cnt_ext, skip_ext, total_ext, limit_sum, limit, cmax, checked;
  logic              in_win, gen_adv, miss, store_prev, cnt_inc;

  // Result register
  logic                 out_valid_q;
  logic                 res_compared_q, res_miss_q, res_done_q;
  logic [WORD_W-1:0]    res_aligned_q, res_expected_q;
  logic [COUNTED_W-1:0] res_counted_q;

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;
  assign cfg_xfer    = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_q <= ALIGN_DIRECT;
      skip_q  <= '0;
      total_q <= TOTAL_RESET;
    end else if (cfg_xfer) begin
      case (cfg_i.index)
        REG_ALIGN: align_q <= cfg_i.data[ALIGN_W-1:0];
        REG_SKIP:  skip_q  <= cfg_i.data[SKIP_W-1:0];
        REG_TOTAL: total_q <= cfg_i.data[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Pattern generator
  assign gen_ctrl.load    = cfg_xfer && (cfg_i.index == REG_SEED);
  assign gen_ctrl.advance = proc && gen_adv;

  p31wc_gen u_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (gen_ctrl),
    .seed_i (cfg_i.data[GEN_W-1:0]),
    .word_o (gen_word)
  );

  // A word is processed when the result register is free or being emptied.
  assign proc         = in_valid_q && (!out_valid_q || result_o.ready);
  assign word_i.ready = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (word_i.valid && word_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_i.valid && word_i.ready) begin
      in_word_q <= word_i.received_word;
    end
  end

  // Mode decode
  always_comb begin
    case (align_q)
      ALIGN_LEFT:  mode = ALIGN_LEFT;
      ALIGN_RIGHT: mode = ALIGN_RIGHT;
      default:     mode = ALIGN_DIRECT;
    endcase
  end

  // Check window and run limit
  assign cnt_ext   = CMP_W'(cnt_q);
  assign skip_ext  = CMP_W'(skip_q);
  assign total_ext = CMP_W'(total_q);
  assign cmax      = CMP_W'({COUNT_WIDTH{1'b1}});
  assign limit_sum = skip_ext + total_ext;
  assign limit     = (limit_sum > cmax) ? cmax : limit_sum;
  assign checked   = cnt_ext - skip_ext;
  assign in_win    = (cnt_ext >= skip_ext) && (checked < total_ext);
  assign gen_adv   = in_win && ((mode != ALIGN_LEFT) || prev_valid_q);

  // Alignment of the received word
  always_comb begin
    case (mode)
      ALIGN_LEFT:  aligned = {prev_word_q[WORD_W-2:0], in_word_q[WORD_W-1]};
      ALIGN_RIGHT: aligned = {prev_valid_q & prev_word_q[0], in_word_q[WORD_W-1:1]};
      default:     aligned = in_word_q;
    endcase
  end

  assign miss       = gen_adv && (aligned != gen_word);
  assign store_prev = (mode == ALIGN_LEFT) || ((mode == ALIGN_RIGHT) && in_win);
  assign cnt_inc    = ((mode != ALIGN_LEFT) || prev_valid_q) && (cnt_ext < limit);

  assign cnt_d = cnt_inc ? cnt_q + 1'b1 : cnt_q;
  assign err_d = (miss && (err_q != '1)) ? err_q + 1'b1 : err_q;

  // State update, once per processed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_word_q  <= '0;
      prev_valid_q <= 1'b0;
      cnt_q        <= '0;
      err_q        <= '0;
      first_q      <= 1'b0;
      first_idx_q  <= '0;
    end else if (proc) begin
      cnt_q <= cnt_d;
      err_q <= err_d;
      if (store_prev) begin
        prev_word_q  <= in_word_q;
        prev_valid_q <= 1'b1;
      end
      if (miss && !first_q) begin
        first_q     <= 1'b1;
        first_idx_q <= (checked > CMP_W'(POS_MAX)) ? POS_MAX : checked[POS_W-1:0];
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_compared_q <= gen_adv;
      res_miss_q     <= miss;
      res_aligned_q  <= aligned;
      res_expected_q <= gen_adv ? gen_word : '0;
      res_counted_q  <= COUNTED_W'(cnt_d);
      res_done_q     <= CMP_W'(cnt_d) >= limit;
    end
  end

  assign result_o.valid                = out_valid_q;
  assign result_o.compared             = res_compared_q;
  assign result_o.mismatch             = res_miss_q;
  assign result_o.aligned_word         = res_aligned_q;
  assign result_o.expected_word        = res_expected_q;
  assign result_o.error_total          = err_q;
  assign result_o.first_error_seen     = first_q;
  assign result_o.first_error_position = first_idx_q;
  assign result_o.words_counted        = res_counted_q;
  assign result_o.run_done             = res_done_q;

  // The error count only grows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> err_q >= $past(err_q))
    else $error("error count decreased");

  // Once a first error is recorded, its flag and index stay.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_q |=> first_q && $stable(first_idx_q))
    else $error("first error record changed");

  // While a result is stalled no word is processed, so the counters hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_o.ready |=> $stable(cnt_q) && $stable(err_q))
    else $error("state changed while the result was stalled");

  // A reported mismatch is always on a compared word with its count recorded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_miss_q |-> res_compared_q && first_q && (err_q != '0))
    else $error("mismatch reported without error bookkeeping");

endmodule

[rtl/core/p31wc_gen.sv]
module p31wc_gen
  import p31wc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gen_ctrl_t         ctrl_i,
  input  logic [GEN_W-1:0]  seed_i,
  output logic [WORD_W-1:0] word_o
);

  logic [GEN_W-1:0] state_q, state_d;
  logic [GEN_W-1:0] state_next;

  // Run the shift register 32 bits ahead; every output bit is a fixed XOR of
  // state bits, so the unrolled form stays shallow.
  always_comb begin
    logic [GEN_W-1:0]  s;
    logic [WORD_W-1:0] w;
    logic              nb;
    s = state_q;
    w = '0;
    for (int i = 0; i < WORD_W; i++) begin
      nb = s[TAP_A] ^ s[TAP_B];
      s  = {s[GEN_W-2:0], nb};
      w  = {w[WORD_W-2:0], nb};
    end
    state_next = s;
    word_o     = w;
  end

  // A seed write takes priority; otherwise step once per checked word.
  always_comb begin
    state_d = state_q;
    if (ctrl_i.load) begin
      state_d = seed_i;
    end else if (ctrl_i.advance) begin
      state_d = state_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GEN_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  // A running generator never falls into the all-zero lockup state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != '0) && ctrl_i.advance && !ctrl_i.load |=> state_q != '0)
    else $error("generator fell into the zero state");

endmodule
